[hdl/gnsa_pkg.sv]
// ----------------------------------------------------------------------------
// gnsa_pkg
// Shared types and constants for the N-dimensional gather slice address
// generator: transfer payloads, register indexes and field widths.
// ----------------------------------------------------------------------------
package gnsa_pkg;

    // tensor dimensions held in configuration
    localparam int MAX_RANK   = 4;

    // field widths
    localparam int IDX_W      = 32;
    localparam int DIM_W      = 16;
    localparam int OFF_W      = 31;
    localparam int RANK_W     = 3;
    localparam int POS_W      = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DIM_ZERO    = 3'd0,
        REG_DIM_ONE     = 3'd1,
        REG_DIM_TWO     = 3'd2,
        REG_DIM_THREE   = 3'd3,
        REG_TENSOR_RANK = 3'd4,
        REG_TUPLE_DEPTH = 3'd5
    } cfg_reg_t;

    // one index component transfer
    typedef struct packed {
        logic signed [IDX_W-1:0] index_value;
        logic                    batch_start;
    } index_item_t;

    // one slice address transfer
    typedef struct packed {
        logic [OFF_W-1:0] source_offset;
        logic [OFF_W-1:0] dest_offset;
        logic [OFF_W-1:0] slice_length;
        logic             index_error;
    } result_item_t;

endpackage

[hdl/gather_nd_slice_address.sv]
// ----------------------------------------------------------------------------
// gather_nd_slice_address
// Slice address generator for an N-dimensional gather. Index components arrive
// one per transfer; each is range-checked against its dimension and multiplied
// by the row-major stride of that dimension, and the products are summed. The
// last component of a tuple produces one result: source offset (0 on error),
// destination offset (slice number times slice length), slice length and an
// error flag. The block takes one component per cycle unless a waiting result
// stalls it; a component is loaded into the input register when accepted and
// passes through the product register, and the last component of a tuple then
// loads the result register. One 16x31 multiply per component and one 31x31
// multiply per tuple sit in that path. The dimension strides are products of
// the configuration registers and are rebuilt in two registered steps after
// each configuration write.
// ----------------------------------------------------------------------------
module gather_nd_slice_address
    import gnsa_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  index_valid,
    output logic                  index_ready,
    input  index_item_t           index_item,
    output logic                  result_valid,
    input  logic                  result_ready,
    output result_item_t          result_item,
    input  logic                  cfg_write_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // configuration
    logic [DIM_W-1:0]       dim_zero_reg;
    logic [DIM_W-1:0]       dim_one_reg;
    logic [DIM_W-1:0]       dim_two_reg;
    logic [DIM_W-1:0]       dim_three_reg;
    logic [RANK_W-1:0]      tensor_rank_reg;
    logic [RANK_W-1:0]      tuple_depth_reg;

    // derived shape
    logic [RANK_W-1:0]      rank_eff;
    logic [RANK_W-1:0]      depth_eff;
    logic [DIM_W-1:0]       ext_one;
    logic [DIM_W-1:0]       ext_two;
    logic [DIM_W-1:0]       ext_three;
    logic [2*DIM_W-1:0]     t23_full;
    logic [DIM_W+OFF_W-1:0] t1_full;
    logic [OFF_W-1:0]       t23_reg;
    logic [OFF_W-1:0]       t1_reg;

    // input stage
    logic                   v1_reg;
    logic [IDX_W-1:0]       idx1_reg;
    logic                   first1_reg;
    logic [POS_W-1:0]       pos_reg;
    logic [POS_W-1:0]       pos_cur;
    logic [DIM_W-1:0]       ext_cur;
    logic [OFF_W-1:0]       stride_cur;
    logic                   bad_cur;
    logic                   last_cur;
    logic [DIM_W+OFF_W-1:0] prod_full;
    logic [OFF_W-1:0]       prod_cur;

    // product stage
    logic                   v2_reg;
    logic [OFF_W-1:0]       prod2_reg;
    logic                   bad2_reg;
    logic                   last2_reg;
    logic                   first2_reg;
    logic [OFF_W-1:0]       offset_reg;
    logic                   tuple_bad_reg;
    logic [OFF_W-1:0]       slice_count_reg;
    logic [OFF_W-1:0]       offset_base;
    logic                   bad_base;
    logic [OFF_W-1:0]       count_base;
    logic [OFF_W-1:0]       offset_next;
    logic                   bad_next;
    logic [OFF_W-1:0]       slen_cur;
    logic [2*OFF_W-1:0]     dest_full;

    // result stage
    logic                   result_valid_reg;
    result_item_t           result_reg;
    result_item_t           result_next;

    // flow control
    logic                   out_free;
    logic                   s2_ready;
    logic                   s2_move;
    logic                   s1_ready;
    logic                   s1_move;
    logic                   accept;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_zero_reg    <= DIM_W'(1);
            dim_one_reg     <= DIM_W'(1);
            dim_two_reg     <= DIM_W'(1);
            dim_three_reg   <= DIM_W'(1);
            tensor_rank_reg <= RANK_W'(1);
            tuple_depth_reg <= RANK_W'(1);
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                REG_DIM_ZERO:    dim_zero_reg    <= cfg_data;
                REG_DIM_ONE:     dim_one_reg     <= cfg_data;
                REG_DIM_TWO:     dim_two_reg     <= cfg_data;
                REG_DIM_THREE:   dim_three_reg   <= cfg_data;
                REG_TENSOR_RANK: tensor_rank_reg <= cfg_data[RANK_W-1:0];
                REG_TUPLE_DEPTH: tuple_depth_reg <= cfg_data[RANK_W-1:0];
                default:         ;
            endcase
        end
    end

    // clamp rank and depth, dimensions beyond the rank count as one
    always_comb
    begin
        if (tensor_rank_reg == '0)
            rank_eff = RANK_W'(1);
        else if (tensor_rank_reg > RANK_W'(MAX_RANK))
            rank_eff = RANK_W'(MAX_RANK);
        else
            rank_eff = tensor_rank_reg;

        if (tuple_depth_reg == '0)
            depth_eff = RANK_W'(1);
        else if (tuple_depth_reg > rank_eff)
            depth_eff = rank_eff;
        else
            depth_eff = tuple_depth_reg;

        ext_one   = (rank_eff > RANK_W'(1)) ? dim_one_reg   : DIM_W'(1);
        ext_two   = (rank_eff > RANK_W'(2)) ? dim_two_reg   : DIM_W'(1);
        ext_three = (rank_eff > RANK_W'(3)) ? dim_three_reg : DIM_W'(1);
    end

    // trailing products, one multiply per register
    assign t23_full = ext_two * ext_three;
    assign t1_full  = ext_one * t23_reg;

    always_ff @(posedge clk)
    begin
        t23_reg <= t23_full[OFF_W-1:0];
        t1_reg  <= t1_full[OFF_W-1:0];
    end

    // handshake chain
    assign out_free    = !result_valid_reg || result_ready;
    assign s2_ready    = !v2_reg || !last2_reg || out_free;
    assign s2_move     = v2_reg && s2_ready;
    assign s1_ready    = !v1_reg || s2_ready;
    assign s1_move     = v1_reg && s1_ready;
    assign index_ready = s1_ready;
    assign accept      = index_valid && index_ready;

    // component check and stride product
    always_comb
    begin
        pos_cur = first1_reg ? '0 : pos_reg;

        unique case (pos_cur)
            2'd0:
            begin
                ext_cur    = dim_zero_reg;
                stride_cur = t1_reg;
            end
            2'd1:
            begin
                ext_cur    = ext_one;
                stride_cur = t23_reg;
            end
            2'd2:
            begin
                ext_cur    = ext_two;
                stride_cur = OFF_W'(ext_three);
            end
            default:
            begin
                ext_cur    = ext_three;
                stride_cur = OFF_W'(1);
            end
        endcase

        bad_cur   = idx1_reg[IDX_W-1] || (idx1_reg >= IDX_W'(ext_cur));
        last_cur  = ({1'b0, pos_cur} + RANK_W'(1)) >= depth_eff;
        prod_full = idx1_reg[DIM_W-1:0] * stride_cur;
        prod_cur  = bad_cur ? '0 : prod_full[OFF_W-1:0];
    end

    // input stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            pos_reg <= '0;
        end
        else
        begin
            if (s1_ready)
                v1_reg <= index_valid;
            if (s1_move)
                pos_reg <= last_cur ? '0 : pos_cur + POS_W'(1);
        end
    end

    // input stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            idx1_reg   <= index_item.index_value;
            first1_reg <= index_item.batch_start;
        end
    end

    // product stage payload
    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            prod2_reg  <= prod_cur;
            bad2_reg   <= bad_cur;
            last2_reg  <= last_cur;
            first2_reg <= first1_reg;
        end
    end

    // accumulate and build the result
    always_comb
    begin
        offset_base = first2_reg ? '0 : offset_reg;
        bad_base    = first2_reg ? 1'b0 : tuple_bad_reg;
        count_base  = first2_reg ? '0 : slice_count_reg;
        offset_next = offset_base + prod2_reg;
        bad_next    = bad_base || bad2_reg;

        unique case (depth_eff)
            3'd1:    slen_cur = t1_reg;
            3'd2:    slen_cur = t23_reg;
            3'd3:    slen_cur = OFF_W'(ext_three);
            default: slen_cur = OFF_W'(1);
        endcase

        dest_full = count_base * slen_cur;

        result_next.source_offset = bad_next ? '0 : offset_next;
        result_next.dest_offset   = dest_full[OFF_W-1:0];
        result_next.slice_length  = slen_cur;
        result_next.index_error   = bad_next;
    end

    // tuple state and result handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg           <= 1'b0;
            offset_reg       <= '0;
            tuple_bad_reg    <= 1'b0;
            slice_count_reg  <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (s2_ready)
                v2_reg <= v1_reg;

            if (s2_move)
            begin
                if (last2_reg)
                begin
                    offset_reg      <= '0;
                    tuple_bad_reg   <= 1'b0;
                    slice_count_reg <= count_base + OFF_W'(1);
                end
                else
                begin
                    offset_reg      <= offset_next;
                    tuple_bad_reg   <= bad_next;
                    slice_count_reg <= count_base;
                end
            end

            if (s2_move && last2_reg)
                result_valid_reg <= 1'b1;
            else if (result_ready)
                result_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (s2_move && last2_reg)
            result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result_item  = result_reg;

    // checks
    a_error_zero_source: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_item.index_error |-> result_item.source_offset == '0)
        else $error("error result carries a non-zero source offset");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !v1_reg && !v2_reg |-> index_ready)
        else $error("empty pipeline refuses a transfer");

    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        index_valid && index_ready |=> v1_reg)
        else $error("accepted component lost from input stage");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(v2_reg && last2_reg))
        else $error("result raised without a completing tuple");

endmodule
